// ===== hw/rtl/dlbwp_pkg.sv =====
// Shared types and constants for the definite-length block word parser.
// No dependencies.
package dlbwp_pkg;

	localparam logic [7:0] CHAR_HASH  = 8'h23;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_NL    = 8'h0A;

	localparam logic [3:0] MAX_LENGTH_DIGITS = 4'd9;
	localparam int         LEN_W             = 30;

	typedef enum logic [2:0] {
		PH_WAIT   = 3'd0,
		PH_COUNT  = 3'd1,
		PH_DIGITS = 3'd2,
		PH_DATA   = 3'd3,
		PH_TERM   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_DONE   = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_HASH  = 3'd1,
		ERR_COUNT = 3'd2,
		ERR_DIGIT = 3'd3,
		ERR_TERM  = 3'd4
	} err_t;

	// classified input byte, as queued between front and back
	typedef struct packed {
		logic [7:0] value;
		logic       is_digit;
		logic [3:0] digit;
		logic       is_hash;
		logic       is_nl;
	} byte_info_t;

	typedef struct packed {
		kind_t             kind;
		logic [15:0]       sample;
		err_t              error_code;
		logic [LEN_W-1:0]  block_length;
	} result_t;

endpackage

// ===== hw/rtl/dlbwp_fifo.sv =====
// Small register-based FIFO used between the parser stages and at the output.
// No package dependencies.
module dlbwp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== hw/rtl/dlbwp_front.sv =====
// Front end: classifies each received byte (digit, hash, newline).
// Depends on dlbwp_pkg.
module dlbwp_front import dlbwp_pkg::*; (
	input  logic       [7:0] in_byte,
	output byte_info_t       info
);

	logic [3:0] offset;

	assign offset = in_byte[3:0] - CHAR_ZERO[3:0];

	always_comb begin
		info          = '0;
		info.value    = in_byte;
		info.is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
		info.digit    = offset;
		info.is_hash  = (in_byte == CHAR_HASH);
		info.is_nl    = (in_byte == CHAR_NL);
	end

endmodule

// ===== hw/rtl/dlbwp_back.sv =====
// Back end: block parsing state machine, one classified byte per beat.
// Depends on dlbwp_pkg.
module dlbwp_back import dlbwp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  byte_info_t info,
	input  logic       info_empty,
	output logic       info_pop,
	output result_t    res,
	output logic       res_push,
	input  logic       res_full
);

	phase_t            phase_q, phase_d;
	logic [3:0]        digits_left_q, digits_left_d;
	logic [LEN_W-1:0]  length_accum_q, length_accum_d;
	logic [LEN_W-1:0]  payload_left_q, payload_left_d;
	logic [7:0]        low_byte_q, low_byte_d;
	logic              have_low_q, have_low_d;
	logic              go;
	logic [LEN_W-1:0]  acc_next;

	// wait for room at the output so any byte may produce a result
	assign go       = !info_empty && !res_full;
	assign info_pop = go;
	assign acc_next = (length_accum_q << 3) + (length_accum_q << 1)
		+ LEN_W'(info.digit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_WAIT;
			digits_left_q  <= '0;
			length_accum_q <= '0;
			payload_left_q <= '0;
			low_byte_q     <= '0;
			have_low_q     <= 1'b0;
		end else if (go) begin
			phase_q        <= phase_d;
			digits_left_q  <= digits_left_d;
			length_accum_q <= length_accum_d;
			payload_left_q <= payload_left_d;
			low_byte_q     <= low_byte_d;
			have_low_q     <= have_low_d;
		end
	end

	always_comb begin
		phase_d        = phase_q;
		digits_left_d  = digits_left_q;
		length_accum_d = length_accum_q;
		payload_left_d = payload_left_q;
		low_byte_d     = low_byte_q;
		have_low_d     = have_low_q;
		res            = '0;
		res.kind       = KIND_ERROR;
		res.error_code = ERR_NONE;
		res_push       = 1'b0;

		case (phase_q)
			PH_COUNT: begin
				if (!info.is_digit || info.digit == 4'd0
						|| info.digit > MAX_LENGTH_DIGITS) begin
					res_push       = go;
					res.error_code = ERR_COUNT;
				end else begin
					digits_left_d  = info.digit;
					length_accum_d = '0;
					phase_d        = PH_DIGITS;
				end
			end
			PH_DIGITS: begin
				if (!info.is_digit) begin
					res_push       = go;
					res.error_code = ERR_DIGIT;
				end else begin
					length_accum_d = acc_next;
					digits_left_d  = digits_left_q - 4'd1;
					if (digits_left_q == 4'd1) begin
						payload_left_d = acc_next;
						have_low_d     = 1'b0;
						low_byte_d     = '0;
						phase_d        = (acc_next == '0) ? PH_TERM : PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (have_low_q) begin
					res_push   = go;
					res.kind   = KIND_SAMPLE;
					res.sample = {info.value, low_byte_q};
					have_low_d = 1'b0;
				end else begin
					low_byte_d = info.value;
					have_low_d = 1'b1;
				end
				payload_left_d = payload_left_q - 1'b1;
				// last payload byte: an unpaired low byte is dropped
				if (payload_left_q == LEN_W'(1)) begin
					have_low_d = 1'b0;
					phase_d    = PH_TERM;
				end
			end
			PH_TERM: begin
				res_push = go;
				if (!info.is_nl) begin
					res.error_code = ERR_TERM;
				end else begin
					res.kind         = KIND_DONE;
					res.block_length = length_accum_q;
					phase_d          = PH_WAIT;
				end
			end
			default: begin
				if (!info.is_hash) begin
					res_push       = go;
					res.error_code = ERR_HASH;
				end else begin
					phase_d        = PH_COUNT;
					digits_left_d  = '0;
					length_accum_d = '0;
					payload_left_d = '0;
					have_low_d     = 1'b0;
				end
			end
		endcase

		// common recovery after any fault
		if (res.error_code != ERR_NONE) begin
			phase_d        = PH_WAIT;
			digits_left_d  = '0;
			payload_left_d = '0;
			have_low_d     = 1'b0;
		end
	end

endmodule

// ===== hw/rtl/definite_length_block_word_parser.sv =====
// Top level of the definite-length block word parser.
// Depends on dlbwp_pkg, dlbwp_front, dlbwp_back and dlbwp_fifo.

// Parses '#', a digit count, the decimal byte count, the payload and a
// newline, one byte per beat. Payload bytes pair low byte first into signed
// samples; each block ends in one done result carrying the declared length,
// or one error result. A byte is taken every cycle while full is low and the
// result queue is drained; each byte is registered in the byte queue and is
// parsed on its way into the result queue, whose head is on the ports. The
// byte queue and the result queue are QUEUE_DEPTH entries deep.
module definite_length_block_word_parser import dlbwp_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic              [7:0] in_byte,
	output logic                    empty,
	input  logic                    pop,
	output logic              [1:0] result_kind,
	output logic signed      [15:0] sample,
	output logic              [2:0] error_code,
	output logic        [LEN_W-1:0] block_length
);

	byte_info_t info_in;
	byte_info_t info_out;
	logic       info_empty;
	logic       info_pop;
	result_t    res_in;
	result_t    res_out;
	logic       res_push;
	logic       res_full;

	dlbwp_front u_front (
		.in_byte (in_byte),
		.info    (info_in)
	);

	dlbwp_fifo #(
		.WIDTH ($bits(byte_info_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_byte_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (info_in),
		.full    (full),
		.pop     (info_pop),
		.rd_data (info_out),
		.empty   (info_empty)
	);

	dlbwp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.info       (info_out),
		.info_empty (info_empty),
		.info_pop   (info_pop),
		.res        (res_in),
		.res_push   (res_push),
		.res_full   (res_full)
	);

	dlbwp_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign result_kind  = res_out.kind;
	assign sample       = $signed(res_out.sample);
	assign error_code   = res_out.error_code;
	assign block_length = res_out.block_length;

`ifndef NO_ASSERTIONS
	// back end only moves a byte when the result queue has room
	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		info_pop |-> !res_full && !info_empty)
		else $error("byte taken with result queue full");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_kind == KIND_ERROR) |-> (error_code != ERR_NONE && sample == 16'sd0))
		else $error("error result without a code");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_kind != KIND_ERROR) |-> error_code == ERR_NONE)
		else $error("error code on a non-error result");
`endif

endmodule

// ===== sim/definite_length_block_word_parser_tb.sv =====
// Self-checking testbench for definite_length_block_word_parser: directed and random byte
// streams, with results checked against a behavioural parser model kept in the bench.
// Depends on dlbwp_pkg and the RTL of the block.
module definite_length_block_word_parser_tb;
	import dlbwp_pkg::*;

	localparam int TOTAL_BYTES = 1650;
	localparam int QUIET_TAIL  = 250;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_LIMIT = 5000;

	logic             clk;
	logic             arst_n;
	logic             push;
	logic             full;
	logic [7:0]       in_byte;
	logic             empty;
	logic             pop;
	logic [1:0]       result_kind;
	logic signed [15:0] sample;
	logic [2:0]       error_code;
	logic [LEN_W-1:0] block_length;

	definite_length_block_word_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.in_byte      (in_byte),
		.empty        (empty),
		.pop          (pop),
		.result_kind  (result_kind),
		.sample       (sample),
		.error_code   (error_code),
		.block_length (block_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser model state
	phase_t           st_phase;
	logic [3:0]       st_digits;
	logic [LEN_W-1:0] st_len;
	logic [LEN_W-1:0] st_left;
	logic [7:0]       st_low;
	logic             st_have_low;

	result_t pending_results[$];

	int  cycles;
	int  bytes_sent;
	int  mismatches;
	int  n_samples;
	int  n_done;
	int  n_errors;
	bit  gaps_on;
	int  rx_hold;
	int  rx_gap;

	task automatic abort_block(input err_t code, inout result_t r);
		st_phase    = PH_WAIT;
		st_digits   = '0;
		st_left     = '0;
		st_have_low = 1'b0;
		r.kind       = KIND_ERROR;
		r.error_code = code;
	endtask

	task automatic parse_byte(input logic [7:0] b);
		result_t r;
		logic    is_dig;
		logic    emit;
		is_dig = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
		emit   = 1'b0;
		r = '{kind: KIND_SAMPLE, sample: '0, error_code: ERR_NONE, block_length: '0};
		case (st_phase)
		PH_COUNT: begin
			if (!is_dig || b[3:0] == 4'd0 || b[3:0] > MAX_LENGTH_DIGITS) begin
				abort_block(ERR_COUNT, r);
				emit = 1'b1;
			end else begin
				st_digits = b[3:0];
				st_len    = '0;
				st_phase  = PH_DIGITS;
			end
		end
		PH_DIGITS: begin
			if (!is_dig) begin
				abort_block(ERR_DIGIT, r);
				emit = 1'b1;
			end else begin
				st_len    = LEN_W'(st_len * 10 + {26'd0, b[3:0]});
				st_digits = st_digits - 4'd1;
				if (st_digits == 4'd0) begin
					st_left     = st_len;
					st_have_low = 1'b0;
					st_low      = '0;
					st_phase    = (st_len == '0) ? PH_TERM : PH_DATA;
				end
			end
		end
		PH_DATA: begin
			if (st_have_low) begin
				r.sample    = {b, st_low};
				st_have_low = 1'b0;
				emit        = 1'b1;
			end else begin
				st_low      = b;
				st_have_low = 1'b1;
			end
			st_left = st_left - 1'b1;
			// an odd trailing byte is simply forgotten here
			if (st_left == '0) begin
				st_have_low = 1'b0;
				st_phase    = PH_TERM;
			end
		end
		PH_TERM: begin
			if (b != CHAR_NL) begin
				abort_block(ERR_TERM, r);
			end else begin
				st_phase       = PH_WAIT;
				r.kind         = KIND_DONE;
				r.block_length = st_len;
			end
			emit = 1'b1;
		end
		default: begin
			if (b != CHAR_HASH) begin
				abort_block(ERR_HASH, r);
				emit = 1'b1;
			end else begin
				st_phase    = PH_COUNT;
				st_digits   = '0;
				st_len      = '0;
				st_left     = '0;
				st_have_low = 1'b0;
			end
		end
		endcase
		if (emit)
			pending_results.push_back(r);
	endtask

	// predict on each accepted input beat, check each accepted result beat
	always @(posedge clk) begin
		result_t exp_r;
		cycles++;
		if (arst_n) begin
			if (push && !full)
				parse_byte(in_byte);
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: kind %0d sample %0d err %0d len %0d",
							result_kind, sample, error_code, block_length);
				end else begin
					exp_r = pending_results.pop_front();
					if (result_kind !== exp_r.kind || sample !== exp_r.sample ||
							error_code !== exp_r.error_code ||
							block_length !== exp_r.block_length) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected kind %0d sample %0d err %0d len %0d, got kind %0d sample %0d err %0d len %0d",
								exp_r.kind, $signed(exp_r.sample), exp_r.error_code,
								exp_r.block_length, result_kind, sample, error_code,
								block_length);
					end
					case (exp_r.kind)
					KIND_SAMPLE: n_samples++;
					KIND_DONE:   n_done++;
					default:     n_errors++;
					endcase
				end
			end
		end
	end

	// receiver: long hold-offs on request, short random stalls otherwise
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (rx_hold > 0) begin
			pop <= 1'b0;
			rx_hold--;
		end else if (rx_gap > 0) begin
			pop <= 1'b0;
			rx_gap--;
		end else if (gaps_on && $urandom_range(0, 4) == 0) begin
			pop    <= 1'b0;
			rx_gap = $urandom_range(0, 2);
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		push    <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic wait_for_results();
		int guard;
		guard = 0;
		while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (6) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_non_digit();
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v >= CHAR_ZERO && v <= CHAR_NINE);
		return v;
	endfunction

	function automatic logic [7:0] rand_non_hash();
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == CHAR_HASH);
		return v;
	endfunction

	function automatic logic [7:0] rand_non_nl();
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == CHAR_NL);
		return v;
	endfunction

	// '#', digit count, then the length in ndig digits with leading zeros
	task automatic send_header(input int ndig, input int len);
		int scale;
		send_byte(CHAR_HASH);
		send_byte(CHAR_ZERO + 8'(ndig));
		scale = 1;
		repeat (ndig - 1) scale *= 10;
		for (int i = 0; i < ndig; i++) begin
			send_byte(CHAR_ZERO + 8'((len / scale) % 10));
			scale /= 10;
		end
	endtask

	task automatic send_block(input int ndig, input int len, input logic [7:0] term);
		send_header(ndig, len);
		repeat (len) send_byte(8'($urandom_range(0, 255)));
		send_byte(term);
	endtask

	task automatic test_stray_bytes();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CHAR_ZERO);
	endtask

	task automatic test_digit_count_errors();
		send_byte(CHAR_HASH);
		send_byte(CHAR_ZERO);
		send_byte(CHAR_HASH);
		send_byte(CHAR_NINE + 8'd1);
	endtask

	task automatic test_length_digit_error();
		send_byte(CHAR_HASH);
		send_byte(CHAR_ZERO + 8'd2);
		send_byte(CHAR_ZERO + 8'd1);
		send_byte(8'h78);
	endtask

	task automatic test_empty_block();
		send_block(1, 0, CHAR_NL);
	endtask

	// most negative and most positive words, then an odd byte that is dropped
	task automatic test_sample_extremes();
		send_header(1, 5);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(8'hAA);
		send_byte(CHAR_NL);
	endtask

	task automatic test_bad_terminator();
		send_block(1, 1, 8'h58);
	endtask

	// receiver stops for a long stretch while a long block keeps coming
	task automatic test_backpressure();
		rx_hold = 80;
		send_block(2, 48, CHAR_NL);
		wait_for_results();
	endtask

	task automatic test_random_stream();
		int sel;
		int len;
		int ndig;
		int tmp;
		while (bytes_sent < TOTAL_BYTES) begin
			if (bytes_sent > TOTAL_BYTES - QUIET_TAIL)
				gaps_on = 1'b0;
			sel = $urandom_range(0, 99);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
			ndig = 1;
			tmp  = len;
			while (tmp >= 10) begin
				tmp /= 10;
				ndig++;
			end
			ndig = $urandom_range(ndig, 9);
			if (sel < 75) begin
				send_block(ndig, len, CHAR_NL);
			end else if (sel < 82) begin
				repeat ($urandom_range(1, 4)) send_byte(rand_non_hash());
			end else if (sel < 88) begin
				send_byte(CHAR_HASH);
				send_byte(($urandom_range(0, 1) == 0) ? CHAR_ZERO : rand_non_digit());
			end else if (sel < 94) begin
				send_byte(CHAR_HASH);
				send_byte(CHAR_ZERO + 8'($urandom_range(1, 9)));
				repeat ($urandom_range(0, 2)) send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
				send_byte(rand_non_digit());
			end else begin
				send_block(ndig, len, rand_non_nl());
			end
		end
	endtask

	initial begin
		while (cycles < CYCLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles", cycles);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		push        = 1'b0;
		pop         = 1'b0;
		in_byte     = '0;
		cycles      = 0;
		bytes_sent  = 0;
		mismatches  = 0;
		n_samples   = 0;
		n_done      = 0;
		n_errors    = 0;
		gaps_on     = 1'b1;
		rx_hold     = 0;
		rx_gap      = 0;
		st_phase    = PH_WAIT;
		st_digits   = '0;
		st_len      = '0;
		st_left     = '0;
		st_low      = '0;
		st_have_low = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_stray_bytes();
		test_digit_count_errors();
		test_length_digit_error();
		test_empty_block();
		test_sample_extremes();
		test_bad_terminator();
		test_backpressure();
		test_random_stream();

		@(negedge clk);
		push <= 1'b0;
		wait_for_results();
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0d expected results never arrived", pending_results.size());
			mismatches += pending_results.size();
		end
		$display("run covered %0d bytes: %0d samples, %0d finished blocks, %0d errors checked",
			bytes_sent, n_samples, n_done, n_errors);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
